>>> design/lbc_pkg.sv
// shared types, constants and register codes for the line blemish correction unit
package lbc_pkg;

    localparam int MAX_LINES_DEF   = 256;
    localparam int MAX_SAMPLES_DEF = 256;

    // geometry arithmetic width (signed), accumulator width, divider and product widths
    localparam int GEO_W  = 14;
    localparam int ACC_W  = 34;
    localparam int DVD_W  = ACC_W + 16;
    localparam int PROD_W = 49;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [2:0] REG_NUM_LINES     = 3'd0;
    localparam logic [2:0] REG_NUM_SAMPLES   = 3'd1;
    localparam logic [2:0] REG_BAND_ONE_LINE = 3'd2;
    localparam logic [2:0] REG_BAND_TWO_LINE = 3'd3;
    localparam logic [2:0] REG_BAND_WIDTH    = 3'd4;
    localparam logic [2:0] REG_WINDOW_START  = 3'd5;
    localparam logic [2:0] REG_WINDOW_COUNT  = 3'd6;
    localparam logic [2:0] REG_MULTIPLY_MODE = 3'd7;

    localparam logic signed [31:0] FACTOR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FACTOR_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [15:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pixel_out;
        logic               clipped;
    } out_item_t;

    typedef struct packed {
        logic item_load;
        logic mem_we;
        logic addr_input;
        logic addr_nbr;
        logic pix_load;
        logic mul_go;
        logic mul_band;
        logic fix_go;
        logic band_clear;
        logic edge_take;
        logic edge_next;
        logic e_latch;
        logic acc;
        logic div_start;
        logic div_step;
        logic fac_store;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic in_band1;
        logic in_band2;
        logic edge_ok;
        logic win_empty;
        logic j_last;
        logic edge_sel;
        logic band_sel;
        logic div_done;
    } dp_status_t;

endpackage

>>> design/line_blemish_correction_unit.sv
// top level: frame store, controller, datapath and output register
// a write stores at acceptance; a read registers the pixel, then corrects it per band
// compute: per band, clear the sums, sum each counted edge over the window, divide
// (the divider skips its steps when its denominator is zero)
// one item at a time; the single frame ram port and the bit-serial divider set the pace
// reset: registers return to their defaults, both factors clear, frame content undefined
// the output register lets a new item be taken while a finished result waits
module line_blemish_correction_unit #(
    parameter int MAX_LINES   = lbc_pkg::MAX_LINES_DEF,
    parameter int MAX_SAMPLES = lbc_pkg::MAX_SAMPLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lbc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lbc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    import lbc_pkg::*;

    localparam int DEPTH  = MAX_LINES * MAX_SAMPLES;
    localparam int ADDR_W = $clog2(DEPTH);

    ctrl_cmd_t         cmd;
    dp_status_t        stat;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_wdata, mem_rdata;
    out_item_t         result;
    logic              out_load;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    lbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_data.cmd),
        .out_free (!out_valid_reg || out_ready),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    lbc_dpath #(
        .MAX_LINES   (MAX_LINES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .result    (result)
    );

    // frame store, one pixel per row/column slot
    lbc_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (cmd.mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register: holds a result until its transfer
    always_comb
    begin
        priority if (out_load) out_valid_next = 1'b1;
        else if (out_ready)    out_valid_next = 1'b0;
        else                   out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous item still in work");

    // frame writes only come from an accepted write transfer
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_we |-> (in_valid && in_ready && (in_data.cmd == CMD_WRITE)))
        else $error("frame write without a write transfer");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

>>> design/lbc_ram.sv
// generic single-port ram with registered read
module lbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/lbc_ctrl.sv
// sequencing state machine for the line blemish correction unit
module lbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic               out_free,
    output logic               out_load,
    input  lbc_pkg::dp_status_t stat,
    output lbc_pkg::ctrl_cmd_t  cmd
);
    import lbc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDW  = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_FIX1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_FIX2 = 4'd5;
    localparam logic [3:0] S_CB   = 4'd6;
    localparam logic [3:0] S_CE   = 4'd7;
    localparam logic [3:0] S_EA   = 4'd8;
    localparam logic [3:0] S_NA   = 4'd9;
    localparam logic [3:0] S_AC   = 4'd10;
    localparam logic [3:0] S_DS   = 4'd11;
    localparam logic [3:0] S_DV   = 4'd12;
    localparam logic [3:0] S_FS   = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.addr_input = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    unique case (in_cmd)
                        CMD_WRITE:
                        begin
                            cmd.mem_we = stat.in_range;
                            state_next = S_DONE;
                        end
                        CMD_READ:    state_next = stat.in_range ? S_RDW : S_DONE;
                        CMD_COMPUTE: state_next = S_CB;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_RDW:
            begin
                cmd.pix_load = 1'b1;
                priority if (stat.in_band1) state_next = S_MUL1;
                else if (stat.in_band2)     state_next = S_MUL2;
                else                        state_next = S_DONE;
            end
            S_MUL1:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_FIX1;
            end
            S_FIX1:
            begin
                cmd.fix_go = 1'b1;
                state_next = stat.in_band2 ? S_MUL2 : S_DONE;
            end
            S_MUL2:
            begin
                cmd.mul_go   = 1'b1;
                cmd.mul_band = 1'b1;
                state_next   = S_FIX2;
            end
            S_FIX2:
            begin
                cmd.fix_go = 1'b1;
                state_next = S_DONE;
            end
            S_CB:
            begin
                cmd.band_clear = 1'b1;
                state_next     = S_CE;
            end
            S_CE:
            begin
                cmd.edge_take = stat.edge_ok;
                priority if (stat.edge_ok && !stat.win_empty)
                begin
                    state_next = S_EA;
                end
                else if (!stat.edge_sel)
                begin
                    cmd.edge_next = 1'b1;
                end
                else
                begin
                    state_next = S_DS;
                end
            end
            S_EA: state_next = S_NA;
            S_NA:
            begin
                cmd.addr_nbr = 1'b1;
                cmd.e_latch  = 1'b1;
                state_next   = S_AC;
            end
            S_AC:
            begin
                cmd.acc = 1'b1;
                priority if (!stat.j_last)
                begin
                    state_next = S_EA;
                end
                else if (!stat.edge_sel)
                begin
                    cmd.edge_next = 1'b1;
                    state_next    = S_CE;
                end
                else
                begin
                    state_next = S_DS;
                end
            end
            S_DS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DV;
            end
            S_DV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FS;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FS:
            begin
                cmd.fac_store = 1'b1;
                state_next    = stat.band_sel ? S_DONE : S_CB;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> design/lbc_dpath.sv
// configuration registers, geometry, statistics, divider and pixel correction
module lbc_dpath #(
    parameter int MAX_LINES   = lbc_pkg::MAX_LINES_DEF,
    parameter int MAX_SAMPLES = lbc_pkg::MAX_SAMPLES_DEF,
    localparam int ADDR_W = $clog2(MAX_LINES * MAX_SAMPLES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  lbc_pkg::in_item_t   in_data,
    input  lbc_pkg::ctrl_cmd_t  cmd,
    output lbc_pkg::dp_status_t stat,
    output logic [ADDR_W-1:0]   mem_addr,
    output logic [15:0]         mem_wdata,
    input  logic [15:0]         mem_rdata,
    output lbc_pkg::out_item_t  result
);
    import lbc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int Q_W   = PROD_W - 16;
    localparam logic signed [GEO_W-1:0] G_ZERO = GEO_W'(0);
    localparam logic signed [GEO_W-1:0] G_ONE  = GEO_W'(1);

    function automatic logic signed [GEO_W-1:0] ext(input logic [8:0] v);
        ext = $signed({{(GEO_W-9){1'b0}}, v});
    endfunction

    // configuration
    logic [8:0] num_lines_reg, num_samples_reg, band_one_reg, band_two_reg;
    logic [8:0] band_width_reg, window_count_reg;
    logic [7:0] window_start_reg;
    logic       mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lines_reg    <= 9'd256;
            num_samples_reg  <= 9'd256;
            band_one_reg     <= '0;
            band_two_reg     <= '0;
            band_width_reg   <= 9'd1;
            window_start_reg <= '0;
            window_count_reg <= '0;
            mode_reg         <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUM_LINES:     num_lines_reg    <= cfg_data;
                REG_NUM_SAMPLES:   num_samples_reg  <= cfg_data;
                REG_BAND_ONE_LINE: band_one_reg     <= cfg_data;
                REG_BAND_TWO_LINE: band_two_reg     <= cfg_data;
                REG_BAND_WIDTH:    band_width_reg   <= cfg_data;
                REG_WINDOW_START:  window_start_reg <= cfg_data[7:0];
                REG_WINDOW_COUNT:  window_count_reg <= cfg_data;
                REG_MULTIPLY_MODE: mode_reg         <= cfg_data[0];
                default:           mode_reg         <= mode_reg;
            endcase
        end
    end

    // geometry
    logic signed [GEO_W-1:0] lnl, lns, wid, t1, b1, t2, b2;
    logic signed [GEO_W-1:0] bt, bb, ot, ob, edge_row, nbr_row;
    logic signed [GEO_W-1:0] jlo0, jhi0, jhi1, jhi, jlo, nsamp;
    logic signed [GEO_W-1:0] in_row, in_col, it_row, row_sel, col_sel;
    logic                    top_ok, bot_ok;

    logic        band_reg, edge_reg;
    logic [1:0]  edges_reg;
    logic signed [GEO_W-1:0] j_reg;
    in_item_t    item_reg;

    always_comb
    begin
        priority if (num_lines_reg == 9'd0)        lnl = G_ONE;
        else if (ext(num_lines_reg) > GEO_W'(MAX_LINES)) lnl = GEO_W'(MAX_LINES);
        else                                        lnl = ext(num_lines_reg);
        priority if (num_samples_reg == 9'd0)      lns = G_ONE;
        else if (ext(num_samples_reg) > GEO_W'(MAX_SAMPLES)) lns = GEO_W'(MAX_SAMPLES);
        else                                        lns = ext(num_samples_reg);
    end

    assign wid = (band_width_reg == 9'd0) ? G_ONE : ext(band_width_reg);
    assign t1  = ext(band_one_reg) - G_ONE;
    assign b1  = t1 + wid - G_ONE;
    assign t2  = ext(band_two_reg) - G_ONE;
    assign b2  = t2 + wid - G_ONE;

    assign bt = band_reg ? t2 : t1;
    assign bb = band_reg ? b2 : b1;
    assign ot = band_reg ? t1 : t2;
    assign ob = band_reg ? b1 : b2;

    // an edge that touches the other band or its lower neighbour line is skipped
    assign top_ok = (bt > G_ZERO) && (bt < lnl) && !((bt >= ot) && (bt <= ob + G_ONE));
    assign bot_ok = (bb >= G_ZERO) && (bb < lnl - G_ONE)
                    && !((bb >= ot) && (bb <= ob + G_ONE));

    assign edge_row = edge_reg ? bb : bt;
    assign nbr_row  = edge_reg ? bb + G_ONE : bt - G_ONE;

    // sample window
    assign jlo0  = ext({1'b0, window_start_reg});
    assign jhi0  = (window_count_reg != 9'd0) ? jlo0 + ext(window_count_reg) : lns;
    assign jhi1  = (jhi0 > lns) ? lns : jhi0;
    assign jhi   = jhi1;
    assign jlo   = (jlo0 > jhi) ? jhi : jlo0;
    assign nsamp = jhi - jlo;

    assign in_row = ext({1'b0, in_data.row});
    assign in_col = ext({1'b0, in_data.col});
    assign it_row = ext({1'b0, item_reg.row});

    assign row_sel = cmd.addr_input ? in_row : (cmd.addr_nbr ? nbr_row : edge_row);
    assign col_sel = cmd.addr_input ? in_col : j_reg;

    assign mem_addr  = ADDR_W'(row_sel) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(col_sel);
    assign mem_wdata = in_data.pixel_in;

    // statistics, divider and factors
    logic signed [15:0]      e_reg, res_reg;
    logic signed [ACC_W-1:0] esum_reg, nsum_reg, dsum, num, den, den_o;
    logic [ACC_W-1:0]        num_mag, den_mag, dsr_reg, rem_reg;
    logic [ACC_W:0]          trial;
    logic                    ge;
    logic [DVD_W-1:0]        dvd_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    special_reg, neg_reg, clip_reg;
    logic signed [31:0]      f1_reg, f2_reg, fac_next;
    logic                    fac_clip;

    assign dsum  = esum_reg - nsum_reg;
    assign den_o = (edges_reg == 2'd2) ? ACC_W'(nsamp) <<< 1
                 : (edges_reg == 2'd1) ? ACC_W'(nsamp) : ACC_W'(0);
    assign num   = mode_reg ? nsum_reg : dsum;
    assign den   = mode_reg ? esum_reg : den_o;
    assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign den_mag = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        fac_clip = 1'b0;
        fac_next = '0;
        if (special_reg)
        begin
            // zero denominator: gain mode saturates by the neighbour sum sign
            if (mode_reg && (nsum_reg > ACC_W'(0)))
            begin
                fac_next = FACTOR_MAX;
                fac_clip = 1'b1;
            end
            else if (mode_reg && (nsum_reg < ACC_W'(0)))
            begin
                fac_next = FACTOR_MIN;
                fac_clip = 1'b1;
            end
        end
        else if (!neg_reg)
        begin
            if (dvd_reg > DVD_W'(32'h7FFF_FFFF))
            begin
                fac_next = FACTOR_MAX;
                fac_clip = 1'b1;
            end
            else
            begin
                fac_next = $signed(dvd_reg[31:0]);
            end
        end
        else
        begin
            if (dvd_reg > DVD_W'(32'h8000_0000))
            begin
                fac_next = FACTOR_MIN;
                fac_clip = 1'b1;
            end
            else
            begin
                fac_next = -$signed(dvd_reg[31:0]);
            end
        end
    end

    // pixel correction
    logic signed [31:0]       f_sel;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [Q_W-1:0]    qt, qa;
    logic signed [15:0]       fix_next;
    logic                     fix_clip;

    assign f_sel     = cmd.mul_band ? f2_reg : f1_reg;
    assign prod_next = mode_reg ? PROD_W'(res_reg) * PROD_W'(f_sel)
                                : (PROD_W'(res_reg) <<< 16) - PROD_W'(f_sel);
    assign qt = $signed(prod_reg[PROD_W-1:16]);
    // shift floors, so a negative value with a fraction steps back toward zero
    assign qa = (prod_reg[PROD_W-1] && (prod_reg[15:0] != 16'd0)) ? qt + Q_W'(1) : qt;

    always_comb
    begin
        fix_clip = 1'b0;
        if (qa > Q_W'(32767))
        begin
            fix_next = 16'sh7FFF;
            fix_clip = 1'b1;
        end
        else if (qa < Q_W'(-32768))
        begin
            fix_next = 16'sh8000;
            fix_clip = 1'b1;
        end
        else
        begin
            fix_next = qa[15:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg    <= 1'b0;
            edge_reg    <= 1'b0;
            edges_reg   <= '0;
            cnt_reg     <= '0;
            clip_reg    <= 1'b0;
            special_reg <= 1'b0;
            neg_reg     <= 1'b0;
            f1_reg      <= '0;
            f2_reg      <= '0;
        end
        else
        begin
            if (cmd.item_load)
            begin
                band_reg <= 1'b0;
                clip_reg <= 1'b0;
            end
            if (cmd.band_clear)
            begin
                edge_reg  <= 1'b0;
                edges_reg <= '0;
            end
            if (cmd.edge_take)
            begin
                edges_reg <= edges_reg + 2'd1;
            end
            if (cmd.edge_next)
            begin
                edge_reg <= 1'b1;
            end
            if (cmd.div_start)
            begin
                special_reg <= (den == ACC_W'(0));
                neg_reg     <= num[ACC_W-1] ^ den[ACC_W-1];
                cnt_reg     <= (den == ACC_W'(0)) ? CNT_W'(0) : CNT_W'(DVD_W);
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.fac_store)
            begin
                if (band_reg)
                begin
                    f2_reg <= fac_next;
                end
                else
                begin
                    f1_reg <= fac_next;
                end
                clip_reg <= clip_reg | fac_clip;
                band_reg <= 1'b1;
            end
            if (cmd.fix_go)
            begin
                clip_reg <= clip_reg | fix_clip;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= in_data;
            res_reg  <= '0;
        end
        if (cmd.pix_load)
        begin
            res_reg <= $signed(mem_rdata);
        end
        if (cmd.mul_go)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.fix_go)
        begin
            res_reg <= fix_next;
        end
        if (cmd.band_clear)
        begin
            esum_reg <= '0;
            nsum_reg <= '0;
        end
        if (cmd.edge_take)
        begin
            j_reg <= jlo;
        end
        if (cmd.e_latch)
        begin
            e_reg <= $signed(mem_rdata);
        end
        if (cmd.acc)
        begin
            esum_reg <= esum_reg + ACC_W'(e_reg);
            nsum_reg <= nsum_reg + ACC_W'($signed(mem_rdata));
            j_reg    <= j_reg + G_ONE;
        end
        if (cmd.div_start)
        begin
            dvd_reg <= {num_mag, 16'd0};
            dsr_reg <= den_mag;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? ACC_W'(trial - {1'b0, dsr_reg}) : ACC_W'(trial);
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign stat.in_range  = (in_row < lnl) && (in_col < lns);
    assign stat.in_band1  = (it_row >= t1) && (it_row <= b1);
    assign stat.in_band2  = (it_row >= t2) && (it_row <= b2);
    assign stat.edge_ok   = edge_reg ? bot_ok : top_ok;
    assign stat.win_empty = (nsamp == G_ZERO);
    assign stat.j_last    = ((j_reg + G_ONE) == jhi);
    assign stat.edge_sel  = edge_reg;
    assign stat.band_sel  = band_reg;
    assign stat.div_done  = (cnt_reg == CNT_W'(0));

    assign result.pixel_out = res_reg;
    assign result.clipped   = clip_reg;

endmodule

>>> verif/tb_top.sv
// testbench for the line blemish correction unit: random and directed traffic checked against a predictor
`timescale 1ns / 1ps
module tb_top;
    import lbc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    line_blemish_correction_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state: frame copy, written-flags, factors and register shadow
    logic signed [15:0] frame_copy [0:65535];
    bit                 frame_written [0:65535];
    longint             fac_one, fac_two;
    int unsigned        r_lines, r_samples, r_b1, r_b2, r_width, r_wstart, r_wcount, r_mult;

    out_item_t expected_q [$];
    int        fail_count = 0;
    bit        quiet_mode = 1'b0;     // a stretch with no idling on either side
    bit        pause_sends = 1'b0;

    function automatic longint clamp64(longint v, longint lo, longint hi, ref bit clip);
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint pix(int r, int c);
        return frame_copy[r * 256 + c];
    endfunction

    // statistics over the top and bottom edges of one band, excluding edges that touch the other band
    function automatic longint band_gain(int t, int b, int ot, int ob, int lnl,
                                         int jlo, int jhi, ref bit clip);
        longint dsum, nsum, edges, den;
        dsum = 0;
        nsum = 0;
        edges = 0;
        if (t > 0 && t < lnl && !(t >= ot && t <= ob + 1))
        begin
            edges++;
            for (int j = jlo; j < jhi; j++)
            begin
                dsum += pix(t, j) - pix(t - 1, j);
                nsum += pix(t - 1, j);
            end
        end
        if (b >= 0 && b < lnl - 1 && !(b >= ot && b <= ob + 1))
        begin
            edges++;
            for (int j = jlo; j < jhi; j++)
            begin
                dsum += pix(b, j) - pix(b + 1, j);
                nsum += pix(b + 1, j);
            end
        end
        if (r_mult != 0)
        begin
            den = dsum + nsum;
            if (den == 0)
            begin
                if (nsum > 0)
                begin
                    clip = 1'b1;
                    return 64'sh7FFF_FFFF;
                end
                if (nsum < 0)
                begin
                    clip = 1'b1;
                    return -64'sh8000_0000;
                end
                return 0;
            end
            return clamp64(nsum * 65536 / den, -64'sh8000_0000, 64'sh7FFF_FFFF, clip);
        end
        den = edges * (jhi - jlo);
        if (den == 0)
            return 0;
        return clamp64(dsum * 65536 / den, -64'sh8000_0000, 64'sh7FFF_FFFF, clip);
    endfunction

    function automatic longint repair_pixel(longint p, longint f, ref bit clip);
        longint x;
        x = (r_mult != 0) ? p * f : p * 65536 - f;
        return clamp64(x / 65536, -32768, 32767, clip);
    endfunction

    function automatic int eff(int unsigned v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic out_item_t predict_item(in_item_t it);
        out_item_t res;
        bit        clip;
        int        lnl, lns, t1, b1, t2, b2, w, jlo, jhi, row, col;
        longint    v;
        clip = 1'b0;
        v = 0;
        row = int'(it.row);
        col = int'(it.col);
        lnl = eff(r_lines);
        lns = eff(r_samples);
        w = (r_width == 0) ? 1 : r_width;
        t1 = int'(r_b1) - 1;
        b1 = t1 + w - 1;
        t2 = int'(r_b2) - 1;
        b2 = t2 + w - 1;
        if (it.cmd == CMD_WRITE)
        begin
            if (row < lnl && col < lns)
            begin
                frame_copy[row * 256 + col] = it.pixel_in;
                frame_written[row * 256 + col] = 1'b1;
            end
        end
        else if (it.cmd == CMD_COMPUTE)
        begin
            jlo = r_wstart;
            jhi = (r_wcount != 0) ? jlo + int'(r_wcount) : lns;
            if (jhi > lns) jhi = lns;
            if (jlo > jhi) jlo = jhi;
            fac_one = band_gain(t1, b1, t2, b2, lnl, jlo, jhi, clip);
            fac_two = band_gain(t2, b2, t1, b1, lnl, jlo, jhi, clip);
        end
        else if (it.cmd == CMD_READ)
        begin
            if (row < lnl && col < lns)
            begin
                v = pix(row, col);
                if (row >= t1 && row <= b1) v = repair_pixel(v, fac_one, clip);
                if (row >= t2 && row <= b2) v = repair_pixel(v, fac_two, clip);
            end
        end
        res.pixel_out = v[15:0];
        res.clipped = clip;
        return res;
    endfunction

    function automatic bit idle_now();
        return !quiet_mode && ($urandom_range(99) < 25);
    endfunction

    // one item: optional gap, then hold valid until the transfer
    // valid stays up after the transfer until the next send or a drain drops it
    task automatic send_item(in_item_t it);
        while (pause_sends || idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(predict_item(it));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 400000)
        begin
            @(negedge clk);
            guard++;
        end
        // let the block settle past any trailing item
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[8:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_NUM_LINES:     r_lines = val & 9'h1FF;
            REG_NUM_SAMPLES:   r_samples = val & 9'h1FF;
            REG_BAND_ONE_LINE: r_b1 = val & 9'h1FF;
            REG_BAND_TWO_LINE: r_b2 = val & 9'h1FF;
            REG_BAND_WIDTH:    r_width = val & 9'h1FF;
            REG_WINDOW_START:  r_wstart = val & 8'hFF;
            REG_WINDOW_COUNT:  r_wcount = val & 9'h1FF;
            default:           r_mult = val & 1;
        endcase
        @(negedge clk);
    endtask

    task automatic setup(int unsigned lines, int unsigned samples, int unsigned b1,
                         int unsigned b2, int unsigned width, int unsigned ws,
                         int unsigned wc, int unsigned mult);
        wait_drained();
        write_reg(REG_NUM_LINES, lines);
        write_reg(REG_NUM_SAMPLES, samples);
        write_reg(REG_BAND_ONE_LINE, b1);
        write_reg(REG_BAND_TWO_LINE, b2);
        write_reg(REG_BAND_WIDTH, width);
        write_reg(REG_WINDOW_START, ws);
        write_reg(REG_WINDOW_COUNT, wc);
        write_reg(REG_MULTIPLY_MODE, mult);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t mk(logic [1:0] cmd, int r, int c, int p);
        in_item_t it;
        it.cmd = cmd;
        it.row = r[7:0];
        it.col = c[7:0];
        it.pixel_in = p[15:0];
        return it;
    endfunction

    // fill the whole used frame so every later read or compute hits written pixels
    task automatic fill_frame(int lines, int samples, int spread);
        for (int r = 0; r < lines; r++)
            for (int c = 0; c < samples; c++)
                send_item(mk(CMD_WRITE, r, c, $urandom_range(2 * spread) - spread));
    endtask

    function automatic bit readable(int r, int c);
        return !(r < eff(r_lines) && c < eff(r_samples)) || frame_written[r * 256 + c];
    endfunction

    // corner values, out of range access, unknown command, both modes, saturation
    task automatic test_directed();
        setup(4, 4, 2, 3, 1, 0, 0, 0);
        send_item(mk(CMD_WRITE, 0, 0, 32767));
        send_item(mk(CMD_WRITE, 0, 1, -32768));
        send_item(mk(CMD_WRITE, 255, 255, 1234));   // ignored, outside the frame
        fill_frame(4, 4, 32767);
        send_item(mk(CMD_WRITE, 0, 0, 32767));
        send_item(mk(CMD_WRITE, 1, 0, -32768));
        send_item(mk(CMD_READ, 0, 0, 0));
        send_item(mk(CMD_READ, 255, 255, 0));
        send_item(mk(CMD_UNUSED, 255, 0, -1));
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 1, 0, 0));
        send_item(mk(CMD_READ, 2, 3, 0));
        setup(4, 4, 2, 3, 1, 0, 0, 1);
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 1, 0, 0));
        send_item(mk(CMD_READ, 2, 1, 0));
        // gain mode with opposite values in the first edge row and its neighbour row
        for (int c = 0; c < 4; c++)
        begin
            send_item(mk(CMD_WRITE, 0, c, 100));
            send_item(mk(CMD_WRITE, 1, c, -100));
        end
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 1, 2, 0));
    endtask

    // random frames under many geometries; mostly reads, some writes, computes and unknown commands
    task automatic test_random(int rounds, int per_round);
        int lines, samples, kind, r, c;
        for (int k = 0; k < rounds; k++)
        begin
            lines = (k % 5 == 0) ? 1 : $urandom_range(2, 8);
            samples = (k % 7 == 0) ? 1 : $urandom_range(1, 8);
            setup(lines, samples, $urandom_range(0, lines + 1), $urandom_range(0, lines + 1),
                  $urandom_range(0, 3), $urandom_range(0, samples), $urandom_range(0, 9),
                  $urandom_range(0, 1));
            fill_frame(lines, samples, (k % 3 == 0) ? 32767 : $urandom_range(1, 300));
            for (int i = 0; i < per_round; i++)
            begin
                kind = $urandom_range(0, 9);
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lines);
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, samples);
                if (kind < 2)
                    send_item(mk(CMD_WRITE, r, c, $urandom_range(0, 65535)));
                else if (kind < 4)
                    send_item(mk(CMD_COMPUTE, $urandom_range(0, 255), 0, 0));
                else if (kind < 9)
                begin
                    if (readable(r, c)) send_item(mk(CMD_READ, r, c, 0));
                end
                else
                    send_item(mk(CMD_UNUSED, r, c, $urandom_range(0, 65535)));
            end
        end
    endtask

    // full-height frame with the largest band and window settings, then zero line and sample counts
    task automatic test_extremes();
        setup(256, 1, 256, 1, 256, 255, 256, 0);
        fill_frame(256, 1, 32767);
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 255, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 0));
        setup(256, 1, 200, 1, 256, 0, 256, 1);
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 230, 0, 0));
        setup(0, 0, 1, 0, 0, 0, 0, 0);
        send_item(mk(CMD_COMPUTE, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 0));
    endtask

    // hold sends until every pending result has arrived
    task automatic test_drain_pause();
        pause_sends = 1'b1;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        pause_sends = 1'b0;
    endtask

    // result side: random back-pressure, compare each transfer with the oldest expectation
    always @(negedge clk)
        out_ready <= !idle_now();

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: actual %0d/%0b", $time,
                         out_data.pixel_out, out_data.clipped);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.pixel_out !== want.pixel_out)
                begin
                    $display("%0t pixel_out: expected %0d actual %0d", $time,
                             want.pixel_out, out_data.pixel_out);
                    fail_count++;
                end
                if (out_data.clipped !== want.clipped)
                begin
                    $display("%0t clipped: expected %0b actual %0b", $time,
                             want.clipped, out_data.clipped);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 65536; i++)
        begin
            frame_copy[i] = '0;
            frame_written[i] = 1'b0;
        end
        fac_one = 0;
        fac_two = 0;
        r_lines = 256; r_samples = 256; r_b1 = 0; r_b2 = 0;
        r_width = 1; r_wstart = 0; r_wcount = 0; r_mult = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_drain_pause();
        quiet_mode = 1'b1;
        test_random(3, 20);
        quiet_mode = 1'b0;
        test_random(7, 20);
        test_extremes();
        wait_drained();
        if (expected_q.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> line_blemish_correction_unit.f
design/lbc_pkg.sv
design/lbc_ram.sv
design/lbc_ctrl.sv
design/lbc_dpath.sv
design/line_blemish_correction_unit.sv
verif/tb_top.sv
